@@ rtl/lrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lrs_pkg
// Shared widths, codes and controller/datapath interface types of the
// polyphase line resampler.
// ----------------------------------------------------------------------------
package lrs_pkg;

    localparam int MAX_TAPS       = 16;
    localparam int TAP_W          = 4;
    localparam int MAX_PHASES_DEF = 64;
    localparam int MAX_LINE       = 4096;
    localparam int COEF_FRAC_BITS = 14;
    localparam int UPSCALE_LIMIT  = 8;
    localparam int MAX_RESULTS    = 64;
    localparam int CNT_W          = 7;

    localparam int SAMPLE_W   = 14;
    localparam int COEF_W     = 16;
    localparam int IDX_W      = 10;
    localparam int SRC_W      = 13;
    localparam int DST_W      = 16;
    localparam int RS_W       = 13;
    localparam int RD_CFG_W   = 7;
    localparam int TAPS_W     = 5;
    localparam int POS_W      = 15;
    localparam int PIX_W      = 8;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + TAP_W + 1;
    localparam int DEN_W      = COEF_W + TAP_W + 1;
    localparam int QW         = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_SRC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_DST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TAPS  = 3'd4;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_COEF   = 1'b1;

    localparam logic [1:0] DSEL_PHASE = 2'd0;
    localparam logic [1:0] DSEL_FILT  = 2'd1;
    localparam logic [1:0] DSEL_CENT  = 2'd2;

    typedef struct packed {
        logic       take;
        logic       tap_start;
        logic       tap_rd;
        logic       tap_mul;
        logic       tap_acc;
        logic       div_start;
        logic [1:0] div_sel;
        logic       phase_load;
        logic       fin_filt;
        logic       fin_copy;
        logic       push;
        logic       push_last;
        logic       adv_start;
        logic       adv_end;
        logic       line_reset;
    } t_cmd;

    typedef struct packed {
        logic in_coef;
        logic end_flag;
        logic stop;
        logic wait_taps;
        logic copy;
        logic stale;
        logic tap_last;
        logic needs_div;
        logic div_done;
        logic div_busy;
        logic out_free;
        logic hold_valid;
    } t_sts;

endpackage

@@ rtl/lrs_div.sv @@
// ----------------------------------------------------------------------------
// lrs_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lrs_div #(
    parameter int W = lrs_pkg::ACC_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_den,
    output logic         o_busy,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W:0]    r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    w_shift;
    logic [W:0]    w_diff;

    assign w_shift = {r_rem[W-1:0], r_quo[W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[W]) begin
                r_rem <= w_diff;
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[W-1:0];
endmodule

@@ rtl/lrs_dp.sv @@
// ----------------------------------------------------------------------------
// lrs_dp
// Datapath: configuration, coefficient memory, sample window, centre
// tracking, shared multiply-accumulate, divider and result registers.
// ----------------------------------------------------------------------------
module lrs_dp #(
    parameter int MAX_PHASES = lrs_pkg::MAX_PHASES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lrs_pkg::t_cmd                      i_cmd,
    output lrs_pkg::t_sts                      o_sts,
    input  logic                               i_cfg_we,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lrs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [lrs_pkg::IN_DATA_W-1:0]      i_in_data,
    input  logic                               i_in_op,
    input  logic                               i_in_end,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [lrs_pkg::OUT_DATA_W-1:0]     o_out_data,
    output logic                               o_out_done,
    output logic                               o_out_last
);
    localparam int TABLE_DEPTH = MAX_PHASES * lrs_pkg::MAX_TAPS;
    localparam int PH_W   = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
    localparam int ADDR_W = PH_W + lrs_pkg::TAP_W;
    localparam int RD_W   = $clog2(MAX_PHASES + 1);
    localparam int FW     = lrs_pkg::QW + 2;
    localparam int AW     = lrs_pkg::ACC_W;
    localparam int SH     = 4 + lrs_pkg::COEF_FRAC_BITS;

    // configuration
    logic [lrs_pkg::SRC_W-1:0]    r_src_len;
    logic [lrs_pkg::DST_W-1:0]    r_dst_len;
    logic [lrs_pkg::RS_W-1:0]     r_ratio_src;
    logic [lrs_pkg::RD_CFG_W-1:0] r_ratio_dst;
    logic [lrs_pkg::TAPS_W-1:0]   r_num_taps;
    logic                         r_stale;

    // line state
    logic signed [lrs_pkg::SAMPLE_W-1:0] r_win [lrs_pkg::MAX_TAPS];
    logic signed [lrs_pkg::COEF_W-1:0]   r_coef_mem [TABLE_DEPTH];
    logic signed [lrs_pkg::COEF_W-1:0]   r_coef_rd;
    logic [lrs_pkg::SRC_W-1:0]           r_src_cnt;
    logic [lrs_pkg::DST_W-1:0]           r_next_dst;
    logic [RD_W-1:0]                     r_crem;
    logic [lrs_pkg::QW-1:0]              r_cquot;
    logic [PH_W-1:0]                     r_phase;
    logic                                r_end;

    // filter
    logic [lrs_pkg::TAP_W-1:0]           r_tap;
    logic signed [lrs_pkg::SAMPLE_W-1:0] r_samp;
    logic                                r_tv;
    logic                                r_tv2;
    logic signed [lrs_pkg::PROD_W-1:0]   r_prod;
    logic signed [AW-1:0]                r_acc;
    logic signed [lrs_pkg::DEN_W-1:0]    r_den;
    logic                                r_skip;

    // results
    logic [lrs_pkg::PIX_W-1:0] r_hold_pix;
    logic [lrs_pkg::POS_W-1:0] r_hold_pos;
    logic                      r_hold_done;
    logic                      r_hold_valid;
    logic                      r_out_valid;
    logic [lrs_pkg::PIX_W-1:0] r_out_pix;
    logic [lrs_pkg::POS_W-1:0] r_out_pos;
    logic                      r_out_done;
    logic                      r_out_last;

    logic [lrs_pkg::TAPS_W-1:0] w_taps;
    logic [RD_W-1:0]            w_phases;
    logic [lrs_pkg::RS_W-1:0]   w_rs;
    logic [lrs_pkg::SRC_W-1:0]  w_sl;
    logic [lrs_pkg::DST_W-1:0]  w_dl;
    logic                       w_copy;
    logic [FW-1:0]              w_first;
    logic [FW-1:0]              w_last;
    logic [FW-1:0]              w_idx;
    logic                       w_idx_ok;
    logic [lrs_pkg::TAP_W-1:0]  w_win_addr;
    logic signed [lrs_pkg::SAMPLE_W-1:0] w_win_rd;
    logic [ADDR_W-1:0]          w_rd_addr;

    logic                    w_div_start;
    logic [AW-1:0]           w_div_num;
    logic [AW-1:0]           w_div_den;
    logic                    w_div_busy;
    logic                    w_div_done;
    logic [AW-1:0]           w_div_quo;
    logic [AW-1:0]           w_div_rem;
    logic [AW-1:0]           w_acc_abs;
    logic [lrs_pkg::DEN_W-1:0] w_den_abs;
    logic [AW-1:0]           w_den16;
    logic [RD_W:0]           w_phase_inc;

    logic [AW:0]             w_fq;
    logic                    w_fgt;
    logic                    w_feq;
    logic [lrs_pkg::PIX_W-1:0] w_filt_pix;
    logic [AW:0]             w_cq;
    logic [lrs_pkg::PIX_W-1:0] w_copy_pix;

    function automatic logic [lrs_pkg::PIX_W-1:0] clamp_pix(input logic [AW:0] v);
        logic [lrs_pkg::PIX_W-1:0] res;
        if (v[AW]) begin
            res = '0;
        end else if (v > (AW+1)'(255)) begin
            res = '1;
        end else begin
            res = v[lrs_pkg::PIX_W-1:0];
        end
        return res;
    endfunction

    // effective configuration
    always_comb begin
        if (r_num_taps < lrs_pkg::TAPS_W'(2)) begin
            w_taps = lrs_pkg::TAPS_W'(2);
        end else if (int'(r_num_taps) > lrs_pkg::MAX_TAPS) begin
            w_taps = lrs_pkg::TAPS_W'(lrs_pkg::MAX_TAPS);
        end else begin
            w_taps = r_num_taps;
        end
        if (r_ratio_dst == '0) begin
            w_phases = RD_W'(1);
        end else if (int'(r_ratio_dst) > MAX_PHASES) begin
            w_phases = RD_W'(MAX_PHASES);
        end else begin
            w_phases = RD_W'(r_ratio_dst);
        end
        w_rs   = (r_ratio_src == '0) ? lrs_pkg::RS_W'(1) : r_ratio_src;
        w_sl   = (int'(r_src_len) < lrs_pkg::MAX_LINE) ? r_src_len
                                                       : lrs_pkg::SRC_W'(lrs_pkg::MAX_LINE);
        w_copy = ({3'b000, r_src_len} == r_dst_len);
        if (w_copy) begin
            w_dl = lrs_pkg::DST_W'(w_sl);
        end else if (r_dst_len < {w_sl, 3'b000}) begin
            w_dl = r_dst_len;
        end else begin
            w_dl = {w_sl, 3'b000};
        end
    end

    // tap window of the current pixel
    always_comb begin
        w_first = {2'b00, r_cquot} + FW'(1) - FW'(w_taps >> 1);
        w_last  = w_first + FW'(w_taps) - FW'(1);
        if ($signed(w_last) > $signed(FW'(w_sl) - FW'(1))) begin
            w_last = FW'(w_sl) - FW'(1);
        end
        w_idx    = w_first + FW'(r_tap);
        w_idx_ok = !w_idx[FW-1] && ($signed(w_idx) < $signed(FW'(r_src_cnt)));
    end

    assign w_win_addr = i_cmd.fin_copy ? r_next_dst[lrs_pkg::TAP_W-1:0]
                                       : w_idx[lrs_pkg::TAP_W-1:0];
    assign w_win_rd   = r_win[w_win_addr];
    assign w_rd_addr  = {r_phase, r_tap};

    // divider operands
    always_comb begin
        w_acc_abs = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
        w_den_abs = r_den[lrs_pkg::DEN_W-1] ? lrs_pkg::DEN_W'(-r_den)
                                            : lrs_pkg::DEN_W'(r_den);
        w_den16   = {{(AW-lrs_pkg::DEN_W-4){1'b0}}, w_den_abs, 4'b0000};
        case (i_cmd.div_sel)
            lrs_pkg::DSEL_FILT: begin
                w_div_num = w_acc_abs;
                w_div_den = w_den16;
            end
            lrs_pkg::DSEL_CENT: begin
                w_div_num = AW'(r_crem) + AW'(w_rs);
                w_div_den = AW'(w_phases);
            end
            default: begin
                w_div_num = AW'(r_next_dst);
                w_div_den = AW'(w_phases);
            end
        endcase
    end

    assign w_div_start = i_cmd.div_start;

    lrs_div #(
        .W(AW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo),
        .o_rem   (w_div_rem)
    );

    // filtered pixel, round half to even then clamp
    always_comb begin
        w_fgt = 1'b0;
        w_feq = 1'b0;
        w_fq  = '0;
        w_filt_pix = '0;
        if (!r_skip) begin
            w_fq  = (AW+1)'(r_acc >>> SH);
            w_fq  = {w_fq[AW-1], w_fq[AW-1:0]};
            w_fgt = r_acc[SH-1:0] > (SH)'(1 << (SH - 1));
            w_feq = r_acc[SH-1:0] == (SH)'(1 << (SH - 1));
            w_filt_pix = clamp_pix(w_fq + (AW+1)'(w_fgt || (w_feq && w_fq[0])));
        end else if (r_den != '0) begin
            w_fq  = {1'b0, w_div_quo};
            w_fgt = {w_div_rem, 1'b0} > {1'b0, w_den16};
            w_feq = {w_div_rem, 1'b0} == {1'b0, w_den16};
            if (!(r_acc[AW-1] ^ r_den[lrs_pkg::DEN_W-1])) begin
                w_filt_pix = clamp_pix(w_fq + (AW+1)'(w_fgt || (w_feq && w_fq[0])));
            end
        end
    end

    always_comb begin
        w_cq = {{(AW+1-(lrs_pkg::SAMPLE_W-4)){w_win_rd[lrs_pkg::SAMPLE_W-1]}},
                w_win_rd[lrs_pkg::SAMPLE_W-1:4]};
        w_copy_pix = clamp_pix(w_cq + (AW+1)'((w_win_rd[3:0] > 4'd8)
                               || ((w_win_rd[3:0] == 4'd8) && w_cq[0])));
    end

    assign w_phase_inc = {1'b0, RD_W'(r_phase)} + (RD_W+1)'(1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_len   <= lrs_pkg::SRC_W'(1);
            r_dst_len   <= lrs_pkg::DST_W'(1);
            r_ratio_src <= lrs_pkg::RS_W'(1);
            r_ratio_dst <= lrs_pkg::RD_CFG_W'(1);
            r_num_taps  <= lrs_pkg::TAPS_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lrs_pkg::CFG_SRC_LEN:   r_src_len   <= i_cfg_data[lrs_pkg::SRC_W-1:0];
                lrs_pkg::CFG_DST_LEN:   r_dst_len   <= i_cfg_data[lrs_pkg::DST_W-1:0];
                lrs_pkg::CFG_RATIO_SRC: r_ratio_src <= i_cfg_data[lrs_pkg::RS_W-1:0];
                lrs_pkg::CFG_RATIO_DST: r_ratio_dst <= i_cfg_data[lrs_pkg::RD_CFG_W-1:0];
                lrs_pkg::CFG_NUM_TAPS:  r_num_taps  <= i_cfg_data[lrs_pkg::TAPS_W-1:0];
                default: ;
            endcase
        end
    end

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_in_op == lrs_pkg::OP_COEF)
                && (int'(i_in_data[23:14]) < TABLE_DEPTH)) begin
            r_coef_mem[ADDR_W'(i_in_data[23:14])] <= $signed(i_in_data[39:24]);
        end
        r_coef_rd <= r_coef_mem[w_rd_addr];
    end

    // window and line counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lrs_pkg::MAX_TAPS; k++) begin
                r_win[k] <= '0;
            end
            r_src_cnt  <= '0;
            r_next_dst <= '0;
            r_crem     <= '0;
            r_cquot    <= '0;
            r_phase    <= '0;
            r_end      <= 1'b0;
            r_stale    <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == lrs_pkg::CFG_RATIO_DST)) begin
                r_stale <= 1'b1;
            end
            if (i_cmd.take && (i_in_op == lrs_pkg::OP_SAMPLE)) begin
                r_end <= i_in_end;
                if (r_src_cnt < w_sl) begin
                    r_win[r_src_cnt[lrs_pkg::TAP_W-1:0]] <= $signed(i_in_data[13:0]);
                    r_src_cnt <= r_src_cnt + lrs_pkg::SRC_W'(1);
                end
            end
            if (i_cmd.phase_load) begin
                r_phase <= PH_W'(w_div_rem);
                r_stale <= 1'b0;
            end
            if (i_cmd.adv_start) begin
                r_next_dst <= r_next_dst + lrs_pkg::DST_W'(1);
                r_phase    <= (w_phase_inc == (RD_W+1)'(w_phases)) ? '0
                                                                   : PH_W'(w_phase_inc);
            end
            if (i_cmd.adv_end) begin
                r_cquot <= r_cquot + lrs_pkg::QW'(w_div_quo);
                r_crem  <= RD_W'(w_div_rem);
            end
            if (i_cmd.line_reset) begin
                r_src_cnt  <= '0;
                r_next_dst <= '0;
                r_crem     <= '0;
                r_cquot    <= '0;
                r_phase    <= '0;
                r_stale    <= 1'b0;
            end
        end
    end

    // multiply-accumulate over the taps
    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_start) begin
            r_tap  <= '0;
            r_acc  <= '0;
            r_den  <= '0;
            r_skip <= 1'b0;
        end
        if (i_cmd.tap_rd) begin
            r_samp <= w_win_rd;
            r_tv   <= w_idx_ok;
        end
        if (i_cmd.tap_mul) begin
            r_prod <= r_samp * r_coef_rd;
            r_tv2  <= r_tv;
            if (r_tv) begin
                r_den <= r_den + {{(lrs_pkg::DEN_W-lrs_pkg::COEF_W){r_coef_rd[lrs_pkg::COEF_W-1]}},
                                  r_coef_rd};
            end else begin
                r_skip <= 1'b1;
            end
        end
        if (i_cmd.tap_acc) begin
            if (r_tv2) begin
                r_acc <= r_acc + {{(AW-lrs_pkg::PROD_W){r_prod[lrs_pkg::PROD_W-1]}}, r_prod};
            end
            r_tap <= r_tap + lrs_pkg::TAP_W'(1);
        end
    end

    // held result and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_out_valid  <= 1'b1;
                r_hold_valid <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.fin_filt || i_cmd.fin_copy) begin
                r_hold_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_pix  <= r_hold_pix;
            r_out_pos  <= r_hold_pos;
            r_out_done <= r_hold_done;
            r_out_last <= i_cmd.push_last;
        end
        if (i_cmd.fin_filt || i_cmd.fin_copy) begin
            r_hold_pix  <= i_cmd.fin_copy ? w_copy_pix : w_filt_pix;
            r_hold_pos  <= r_next_dst[lrs_pkg::POS_W-1:0];
            r_hold_done <= (r_next_dst == w_dl - lrs_pkg::DST_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {1'b0, r_out_pos, r_out_pix};
    assign o_out_done  = r_out_done;
    assign o_out_last  = r_out_last;

    always_comb begin
        o_sts.in_coef    = (i_in_op == lrs_pkg::OP_COEF);
        o_sts.end_flag   = r_end;
        o_sts.stop       = (r_next_dst >= w_dl)
                         || (w_copy && ({3'b000, r_src_cnt} <= r_next_dst));
        o_sts.wait_taps  = !w_copy && ($signed(w_last) >= $signed(FW'(r_src_cnt)));
        o_sts.copy       = w_copy;
        o_sts.stale      = r_stale;
        o_sts.tap_last   = (lrs_pkg::TAPS_W'(r_tap) == w_taps - lrs_pkg::TAPS_W'(1));
        o_sts.needs_div  = r_skip && (r_den != '0);
        o_sts.div_done   = w_div_done;
        o_sts.div_busy   = w_div_busy;
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.hold_valid = r_hold_valid;
    end
endmodule

@@ rtl/lrs_ctrl.sv @@
// ----------------------------------------------------------------------------
// lrs_ctrl
// Controller: accepts requests, walks each destination pixel through the tap
// loop (not in copy mode), border divide and centre update; flushes at line end.
// ----------------------------------------------------------------------------
module lrs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lrs_pkg::t_sts i_sts,
    output lrs_pkg::t_cmd o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHECK  = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_PHWAIT = 4'd3;
    localparam logic [3:0] S_TRD    = 4'd4;
    localparam logic [3:0] S_TMUL   = 4'd5;
    localparam logic [3:0] S_TACC   = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_DWAIT  = 4'd8;
    localparam logic [3:0] S_ADV    = 4'd9;
    localparam logic [3:0] S_AWAIT  = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0]                r_state, n_state;
    logic [lrs_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                      r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pass     = r_pass;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (!i_sts.in_coef) begin
                        n_cnt   = '0;
                        n_pass  = 1'b0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.stop || (r_cnt == lrs_pkg::CNT_W'(lrs_pkg::MAX_RESULTS))
                        || (!r_pass && i_sts.wait_taps)) begin
                    if (!r_pass && i_sts.end_flag) begin
                        n_pass = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (!i_sts.hold_valid || i_sts.out_free) begin
                    o_cmd.push = i_sts.hold_valid;
                    if (i_sts.copy) begin
                        o_cmd.fin_copy = 1'b1;
                        n_cnt   = r_cnt + lrs_pkg::CNT_W'(1);
                        n_state = S_ADV;
                    end else if (i_sts.stale) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = lrs_pkg::DSEL_PHASE;
                        n_state = S_PHWAIT;
                    end else begin
                        o_cmd.tap_start = 1'b1;
                        n_state = S_TRD;
                    end
                end
            end
            S_PHWAIT: begin
                o_cmd.div_sel = lrs_pkg::DSEL_PHASE;
                if (i_sts.div_done) begin
                    o_cmd.phase_load = 1'b1;
                    o_cmd.tap_start  = 1'b1;
                    n_state = S_TRD;
                end
            end
            S_TRD: begin
                o_cmd.tap_rd = 1'b1;
                n_state = S_TMUL;
            end
            S_TMUL: begin
                o_cmd.tap_mul = 1'b1;
                n_state = S_TACC;
            end
            S_TACC: begin
                o_cmd.tap_acc = 1'b1;
                n_state = i_sts.tap_last ? S_FIN : S_TRD;
            end
            S_FIN: begin
                o_cmd.div_sel = lrs_pkg::DSEL_FILT;
                if (i_sts.needs_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DWAIT;
                end else begin
                    o_cmd.fin_filt = 1'b1;
                    n_cnt   = r_cnt + lrs_pkg::CNT_W'(1);
                    n_state = S_ADV;
                end
            end
            S_DWAIT: begin
                o_cmd.div_sel = lrs_pkg::DSEL_FILT;
                if (i_sts.div_done) begin
                    o_cmd.fin_filt = 1'b1;
                    n_cnt   = r_cnt + lrs_pkg::CNT_W'(1);
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                o_cmd.adv_start = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = lrs_pkg::DSEL_CENT;
                n_state = S_AWAIT;
            end
            S_AWAIT: begin
                o_cmd.div_sel = lrs_pkg::DSEL_CENT;
                if (i_sts.div_done) begin
                    o_cmd.adv_end = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                if (!i_sts.hold_valid || i_sts.out_free) begin
                    o_cmd.push       = i_sts.hold_valid;
                    o_cmd.push_last  = 1'b1;
                    o_cmd.line_reset = i_sts.end_flag;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

@@ rtl/polyphase_lanczos_line_resampler.sv @@
// ----------------------------------------------------------------------------
// polyphase_lanczos_line_resampler
// One-axis polyphase resampler with loadable coefficient table.
// ----------------------------------------------------------------------------
// A coefficient load is taken without leaving the idle state. A source sample
// then runs, for each destination pixel it releases, the tap loop in the single
// shared multiply-accumulate unit (filtered pixels only) and a centre update in
// the shared bit-serial divider; a border pixel that needs its sum renormalized
// passes through that divider again, and the first pixel after a ratio_dst write
// uses it once more to find its phase. Results leave through an output register,
// so input is taken while the last result waits.
module polyphase_lanczos_line_resampler #(
    parameter int MAX_PHASES = lrs_pkg::MAX_PHASES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lrs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lrs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // sample[13:0], coef_index[23:14], coef_value[39:24]
    input  logic [lrs_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // operation
    input  logic                               i_s_axis_tuser,
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // pixel[7:0], dst_position[22:8], zero[23]
    output logic [lrs_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // line_done
    output logic                               o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);
    lrs_pkg::t_cmd w_cmd;
    lrs_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    lrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lrs_dp #(
        .MAX_PHASES(MAX_PHASES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_s_axis_tdata),
        .i_in_op     (i_s_axis_tuser),
        .i_in_end    (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_done  (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast)
    );

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    a_push_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> w_sts.out_free)
        else $error("result pushed over a pending one");

    a_ready_divider_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !w_sts.div_busy)
        else $error("request taken while divider busy");

    a_fin_only_when_div_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.fin_filt && w_sts.needs_div) |-> w_sts.div_done)
        else $error("border pixel finished before divide");
endmodule
